[rtl/core/multichannel_position_pid_top_macros.svh]
// Assertion macros for the multichannel position PID controller.
`ifndef MULTICHANNEL_POSITION_PID_TOP_MACROS_SVH
`define MULTICHANNEL_POSITION_PID_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MPP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpp assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpp assertion failed");

`endif

[rtl/core/mpp_pkg.sv]
// Types and constants of the multichannel position PID controller.
package mpp_pkg;

    localparam int CHANNELS_DEFAULT = 8;

    localparam int CHANNEL_W     = 3;
    localparam int POS_W         = 24;
    localparam int GAIN_W        = 24;
    localparam int DEAD_BAND_W   = 16;
    localparam int INTEG_LIMIT_W = 15;
    localparam int INTEG_W       = 16;
    localparam int ERR_W         = POS_W + 1;
    localparam int DRIVE_W       = 32;
    localparam int FRAC_W        = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = GAIN_W;

    localparam int IN_FIELDS_W  = CHANNEL_W + 2 * POS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = CHANNEL_W + DRIVE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [DEAD_BAND_W-1:0]   DEAD_BAND_RESET   = 16'd10;
    localparam logic [INTEG_LIMIT_W-1:0] INTEG_LIMIT_RESET = 15'd500;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_DEAD_BAND   = 3'd3,
        REG_INTEG_LIMIT = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [INTEG_W-1:0] integral;
        logic [ERR_W-1:0]   prev_err;
    } chan_state_t;

endpackage

[rtl/core/multichannel_position_pid_top.sv]
// Top level of the multichannel position PID controller.
// One request is accepted every clock cycle unless m_axis_tready stalls the output. On
// acceptance the request is captured in an input register, then a single stage of logic
// with three multipliers, the dead-band test, the integral clamp, rounding and saturation
// loads the result register and updates the state of the addressed channel in the same
// edge, so consecutive requests for one channel see each other's state without stalls.
// Requests whose channel number is not below CHANNELS yield no result and change nothing.
`include "multichannel_position_pid_top_macros.svh"

module multichannel_position_pid_top #(
    parameter int CHANNELS = mpp_pkg::CHANNELS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Fields from bit 0: channel, target_position, measured_position, zero fill.
    input  logic [mpp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: out_channel, drive_value, zero fill.
    output logic [mpp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0: in_position.
    output logic                                m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wr_en,
    input  logic [mpp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mpp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import mpp_pkg::*;

    localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W     = CHANNEL_W + 2;
    localparam int WIDE_W    = ERR_W + 1;
    localparam int ACC_W     = GAIN_W + WIDE_W + 2;
    localparam int RND_W     = ACC_W - FRAC_W;
    localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

    logic signed [GAIN_W-1:0]        prop_gain_reg;
    logic signed [GAIN_W-1:0]        integ_gain_reg;
    logic signed [GAIN_W-1:0]        deriv_gain_reg;
    logic [DEAD_BAND_W-1:0]          dead_band_reg;
    logic [INTEG_LIMIT_W-1:0]        integ_limit_reg;

    logic                            s1_valid_reg;
    logic [CHANNEL_W-1:0]            s1_channel_reg;
    logic signed [POS_W-1:0]         s1_target_reg;
    logic signed [POS_W-1:0]         s1_measured_reg;

    logic                            out_valid_reg;
    logic [CHANNEL_W-1:0]            out_channel_reg;
    logic [DRIVE_W-1:0]              drive_reg;
    logic                            in_pos_reg;

    chan_state_t                     state_reg [CHANNELS];
    chan_state_t                     state_cur;
    chan_state_t                     state_next;

    logic                            advance;
    logic                            in_range;
    logic [IDX_W-1:0]                idx;
    logic signed [ERR_W-1:0]         err_raw;
    logic signed [WIDE_W-1:0]        err_wide;
    logic signed [WIDE_W-1:0]        band;
    logic                            in_band;
    logic signed [ERR_W-1:0]         err;
    logic signed [INTEG_W-1:0]       integ_old;
    logic signed [ERR_W-1:0]         prev_err;
    logic signed [WIDE_W-1:0]        integ_sum;
    logic signed [WIDE_W-1:0]        limit;
    logic signed [WIDE_W-1:0]        integ_clamped;
    logic signed [INTEG_W-1:0]       integ_new;
    logic signed [WIDE_W-1:0]        err_diff;
    logic signed [GAIN_W+ERR_W-1:0]  prod_p;
    logic signed [GAIN_W+INTEG_W-1:0] prod_i;
    logic signed [GAIN_W+WIDE_W-1:0] prod_d;
    logic signed [ACC_W-1:0]         acc;
    logic signed [RND_W-1:0]         rounded;
    logic [DRIVE_W-1:0]              drive_next;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || advance;
    assign in_range      = ({2'b00, s1_channel_reg} < CMP_W'(CHANNELS));
    assign idx           = IDX_W'(s1_channel_reg);
    assign state_cur     = state_reg[idx];

    always_comb
    begin
        err_raw  = ERR_W'(s1_target_reg) - ERR_W'(s1_measured_reg);
        err_wide = WIDE_W'(err_raw);
        band     = $signed(WIDE_W'(dead_band_reg));
        in_band  = (err_wide >= -band) && (err_wide <= band);

        if (in_band)
        begin
            err       = '0;
            integ_old = '0;
            prev_err  = '0;
        end
        else
        begin
            err       = err_raw;
            integ_old = $signed(state_cur.integral);
            prev_err  = $signed(state_cur.prev_err);
        end

        integ_sum = WIDE_W'(integ_old) + WIDE_W'(err);
        limit     = $signed(WIDE_W'(integ_limit_reg));
        priority if (integ_sum > limit)
        begin
            integ_clamped = limit;
        end
        else if (integ_sum < -limit)
        begin
            integ_clamped = -limit;
        end
        else
        begin
            integ_clamped = integ_sum;
        end
        integ_new = $signed(integ_clamped[INTEG_W-1:0]);

        err_diff = WIDE_W'(err) - WIDE_W'(prev_err);
        prod_p   = prop_gain_reg * err;
        prod_i   = integ_gain_reg * integ_new;
        prod_d   = deriv_gain_reg * err_diff;
        acc      = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d) + ROUND_HALF;
        rounded  = $signed(acc[ACC_W-1:FRAC_W]);

        if ((&rounded[RND_W-1:DRIVE_W-1]) || !(|rounded[RND_W-1:DRIVE_W-1]))
        begin
            drive_next = rounded[DRIVE_W-1:0];
        end
        else if (rounded[RND_W-1])
        begin
            drive_next = {1'b1, {(DRIVE_W-1){1'b0}}};
        end
        else
        begin
            drive_next = {1'b0, {(DRIVE_W-1){1'b1}}};
        end

        state_next.integral = integ_new;
        state_next.prev_err = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            dead_band_reg   <= DEAD_BAND_RESET;
            integ_limit_reg <= INTEG_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:   prop_gain_reg   <= $signed(cfg_data[GAIN_W-1:0]);
                REG_INTEG_GAIN:  integ_gain_reg  <= $signed(cfg_data[GAIN_W-1:0]);
                REG_DERIV_GAIN:  deriv_gain_reg  <= $signed(cfg_data[GAIN_W-1:0]);
                REG_DEAD_BAND:   dead_band_reg   <= cfg_data[DEAD_BAND_W-1:0];
                REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[INTEG_LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg && in_range;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_channel_reg  <= s_axis_tdata[CHANNEL_W-1:0];
            s1_target_reg   <= $signed(s_axis_tdata[CHANNEL_W+POS_W-1:CHANNEL_W]);
            s1_measured_reg <= $signed(s_axis_tdata[CHANNEL_W+2*POS_W-1:CHANNEL_W+POS_W]);
        end
        if (advance && s1_valid_reg && in_range)
        begin
            out_channel_reg <= s1_channel_reg;
            drive_reg       <= drive_next;
            in_pos_reg      <= in_band;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (advance && s1_valid_reg && in_range)
        begin
            state_reg[idx] <= state_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = in_pos_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, drive_reg, out_channel_reg};

    `MPP_ASSERT_SAME(a_in_position_drive_zero, m_axis_tvalid && m_axis_tuser, drive_reg == '0)
    `MPP_ASSERT_NEXT(a_result_follows, s1_valid_reg && advance && in_range, m_axis_tvalid)
    `MPP_ASSERT_NEXT(a_no_result_out_of_range, s1_valid_reg && advance && !in_range,
        !m_axis_tvalid)

endmodule

[test/multichannel_position_pid_top_tb.sv]
// Self-checking testbench for the multichannel position PID controller.
module multichannel_position_pid_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mpp_pkg::*;

    localparam int     CHANNELS    = CHANNELS_DEFAULT;
    localparam int     MAX_GAP     = 12;
    localparam int     LONG_HOLD   = 100;
    localparam int     PHASE_ITEMS = 75;
    localparam longint ROUND_HALF  = longint'(1) <<< (FRAC_W - 1);
    localparam longint DRIVE_MAX   = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_MIN   = -(longint'(1) <<< (DRIVE_W - 1));
    localparam longint POS_MAX     = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint POS_MIN     = -(longint'(1) <<< (POS_W - 1));
    localparam longint GAIN_MAX    = (longint'(1) <<< (GAIN_W - 1)) - 1;
    localparam longint GAIN_MIN    = -(longint'(1) <<< (GAIN_W - 1));
    localparam longint UNITY_GAIN  = longint'(1) <<< FRAC_W;
    localparam longint BAND_MAX    = (longint'(1) <<< DEAD_BAND_W) - 1;
    localparam longint LIMIT_MAX   = (longint'(1) <<< INTEG_LIMIT_W) - 1;

    typedef struct {
        logic [CHANNEL_W-1:0] chan;
        logic [POS_W-1:0]     target;
        logic [POS_W-1:0]     measured;
        int                   gap;
        bit                   after_drain;
    } pos_request_t;

    typedef struct {
        logic [CHANNEL_W-1:0] chan;
        logic [DRIVE_W-1:0]   drive;
        logic                 at_pos;
    } drive_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    longint kp_cfg    = 0;
    longint ki_cfg    = 0;
    longint kd_cfg    = 0;
    longint band_cfg  = longint'(DEAD_BAND_RESET);
    longint limit_cfg = longint'(INTEG_LIMIT_RESET);
    longint chan_integral [CHANNELS] = '{default: 0};
    longint chan_prev_err [CHANNELS] = '{default: 0};

    pos_request_t  pending_reqs[$];
    drive_result_t expected_drives[$];

    int reqs_offered   = 0;
    int reqs_taken     = 0;
    int results_seen   = 0;
    int results_acked  = 0;
    int fail_count     = 0;
    int gap_count      = 0;
    int rx_stall       = 0;
    int hold_at_result = -1;
    int last_chan      = 0;
    bit steady         = 1'b0;

    multichannel_position_pid_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic drive_result_t pid_predict(logic [CHANNEL_W-1:0] chan,
                                                  logic [POS_W-1:0] target,
                                                  logic [POS_W-1:0] measured);
        longint        err;
        longint        integ;
        longint        prev;
        longint        acc;
        longint        rounded;
        drive_result_t res;
        err   = longint'(signed'(target)) - longint'(signed'(measured));
        integ = chan_integral[chan];
        prev  = chan_prev_err[chan];
        res.at_pos = (err >= -band_cfg && err <= band_cfg);
        if (res.at_pos)
        begin
            err   = 0;
            integ = 0;
            prev  = 0;
        end
        integ = integ + err;
        if (integ > limit_cfg)
            integ = limit_cfg;
        else if (integ < -limit_cfg)
            integ = -limit_cfg;
        acc     = kp_cfg * err + ki_cfg * integ + kd_cfg * (err - prev);
        rounded = (acc + ROUND_HALF) >>> FRAC_W;
        if (rounded > DRIVE_MAX)
            rounded = DRIVE_MAX;
        else if (rounded < DRIVE_MIN)
            rounded = DRIVE_MIN;
        chan_integral[chan] = integ;
        chan_prev_err[chan] = err;
        res.chan  = chan;
        res.drive = DRIVE_W'(rounded);
        return res;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_PROP_GAIN:   kp_cfg    = longint'(signed'(data));
            REG_INTEG_GAIN:  ki_cfg    = longint'(signed'(data));
            REG_DERIV_GAIN:  kd_cfg    = longint'(signed'(data));
            REG_DEAD_BAND:   band_cfg  = longint'(data[DEAD_BAND_W-1:0]);
            REG_INTEG_LIMIT: limit_cfg = longint'(data[INTEG_LIMIT_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_config(longint kp, longint ki, longint kd, longint band,
                              longint limit, bit with_spare);
        write_reg(REG_PROP_GAIN, CFG_DATA_W'(kp));
        write_reg(REG_INTEG_GAIN, CFG_DATA_W'(ki));
        write_reg(REG_DERIV_GAIN, CFG_DATA_W'(kd));
        write_reg(REG_DEAD_BAND, CFG_DATA_W'(band));
        write_reg(REG_INTEG_LIMIT, CFG_DATA_W'(limit));
        if (with_spare)
            for (int i = int'(REG_INTEG_LIMIT) + 1; i < (1 << CFG_INDEX_W); i++)
                write_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_req(int chan, longint target, longint measured, bit after_drain = 0);
        pos_request_t req;
        req.chan        = CHANNEL_W'(chan);
        req.target      = POS_W'(target);
        req.measured    = POS_W'(measured);
        req.gap         = steady ? 0 : $urandom_range(0, MAX_GAP);
        req.after_drain = after_drain;
        pending_reqs.push_back(req);
    endtask

    // Small errors around the dead band are the most common kind, so that the integral builds up over runs
    // of requests on one channel; the rest are medium errors and unrelated positions.
    task automatic push_random_req(bit after_drain);
        longint meas;
        longint err;
        longint tgt;
        int     kind;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 1))
            last_chan = $urandom_range(0, CHANNELS - 1);
        meas = longint'(signed'(POS_W'($urandom)));
        if (kind < 4)
            err = longint'($urandom_range(0, int'(2 * band_cfg + 4))) - band_cfg - 2;
        else if (kind < 7)
            err = longint'($urandom_range(0, 8192)) - 4096;
        else
            err = longint'(signed'(POS_W'($urandom))) - meas;
        tgt = meas + err;
        if (tgt > POS_MAX || tgt < POS_MIN)
            tgt = meas - err;
        push_req(last_chan, tgt, meas, after_drain);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || reqs_taken != reqs_offered
               || expected_drives.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_phase();
        for (int i = 0; i < PHASE_ITEMS; i++)
            push_random_req(i == PHASE_ITEMS / 2);
        wait_idle();
    endtask

    function automatic longint rand_gain();
        return longint'($urandom_range(0, 1 << 21)) - (longint'(1) << 20);
    endfunction

    always @(negedge clk)
    begin
        pos_request_t req;
        if (rst_n && reqs_taken == reqs_offered)
        begin
            if (pending_reqs.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (pending_reqs[0].after_drain && expected_drives.size() != 0)
                s_axis_tvalid <= 1'b0;
            else if (gap_count < pending_reqs[0].gap)
            begin
                gap_count++;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                req = pending_reqs.pop_front();
                s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}},
                                  req.measured, req.target, req.chan};
                s_axis_tvalid <= 1'b1;
                reqs_offered++;
                gap_count = 0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (results_seen != results_acked)
            begin
                results_acked = results_seen;
                rx_stall = steady ? 0 : $urandom_range(0, MAX_GAP);
                if (results_seen == hold_at_result)
                    rx_stall = LONG_HOLD;
            end
            m_axis_tready <= (rx_stall == 0);
            if (rx_stall > 0)
                rx_stall--;
        end
    end

    always @(posedge clk)
    begin
        drive_result_t want;
        logic [CHANNEL_W-1:0] got_chan;
        logic [DRIVE_W-1:0]   got_drive;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_drives.push_back(pid_predict(
                    s_axis_tdata[CHANNEL_W-1:0],
                    s_axis_tdata[CHANNEL_W +: POS_W],
                    s_axis_tdata[CHANNEL_W + POS_W +: POS_W]));
                reqs_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got_chan  = m_axis_tdata[CHANNEL_W-1:0];
                got_drive = m_axis_tdata[CHANNEL_W +: DRIVE_W];
                if (expected_drives.size() == 0)
                begin
                    $error("result on channel %0d with no request outstanding", got_chan);
                    fail_count++;
                end
                else
                begin
                    want = expected_drives.pop_front();
                    if (got_chan !== want.chan)
                    begin
                        $error("out_channel: expected %0d, got %0d", want.chan, got_chan);
                        fail_count++;
                    end
                    if (got_drive !== want.drive)
                    begin
                        $error("drive_value: expected %0d, got %0d",
                               $signed(want.drive), $signed(got_drive));
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.at_pos)
                    begin
                        $error("in_position: expected %0d, got %0d", want.at_pos, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Settings after reset: zero gains, so only the dead-band flag moves.
        push_req(0, 10, 0);
        push_req(1, -10, 0);
        push_req(2, 11, 0);
        push_req(3, -11, 0);
        push_req(4, 0, 0);
        wait_idle();

        set_config(UNITY_GAIN, UNITY_GAIN / 2, UNITY_GAIN / 4, 5, 100, 0);
        push_req(5, POS_MAX, POS_MIN);
        push_req(6, POS_MIN, POS_MAX);
        push_req(7, 5, 0);
        push_req(7, 0, 5);
        push_req(7, 6, 0);
        push_req(7, -6, 0);
        push_req(0, 60, 0);
        push_req(0, 60, 0);
        push_req(0, -300, 0);
        wait_idle();

        set_config(GAIN_MAX, GAIN_MIN, GAIN_MAX, 0, LIMIT_MAX, 0);
        push_req(2, POS_MAX, POS_MIN);
        push_req(2, POS_MIN, POS_MAX);
        push_req(3, 1, 0);
        push_req(3, -1, 0);
        wait_idle();

        // Half-unit products show the round-half-up behaviour in both signs.
        set_config(UNITY_GAIN / 2, 0, 0, 0, LIMIT_MAX, 0);
        push_req(4, 1, 0);
        push_req(4, -1, 0);
        push_req(4, 3, 0);
        push_req(4, -3, 0);
        wait_idle();

        set_config(UNITY_GAIN, UNITY_GAIN, 0, BAND_MAX, 0, 1);
        push_req(1, BAND_MAX, 0);
        push_req(1, -BAND_MAX - 1, 0);
        wait_idle();

        // Back-to-back requests while the output is held off for a long stretch.
        steady = 1'b1;
        hold_at_result = results_seen + 20;
        set_config(rand_gain(), rand_gain(), rand_gain(), $urandom_range(0, 64),
                   $urandom_range(0, LIMIT_MAX), 0);
        run_random_phase();
        steady = 1'b0;

        set_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, 0, LIMIT_MAX, 0);
        run_random_phase();
        set_config(GAIN_MIN, GAIN_MIN, GAIN_MIN, BAND_MAX, 0, 0);
        run_random_phase();
        set_config($urandom, $urandom, $urandom, $urandom, $urandom, 1);
        run_random_phase();
        for (int p = 0; p < 2; p++)
        begin
            set_config(rand_gain(), rand_gain(), rand_gain(), $urandom_range(0, 64),
                       $urandom_range(0, LIMIT_MAX), 0);
            run_random_phase();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("multichannel_position_pid_top: match");
        else
            $display("multichannel_position_pid_top: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("multichannel_position_pid_top: mismatch");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/mpp_pkg.sv
rtl/core/multichannel_position_pid_top.sv
test/multichannel_position_pid_top_tb.sv
